### design/cew_pkg.sv
// Shared types, codes and helpers for the check-in escalation watchdog.
package cew_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned HoursW = 8;
  localparam int unsigned CfgW   = 32;

  localparam logic [TimeW-1:0]  CheckinIntervalRst = 32'd43200;
  localparam logic [TimeW-1:0]  PanicDelayRst      = 32'd300;
  localparam logic [TimeW-1:0]  NoticeDelayRst     = 32'd120;
  localparam logic [CountW-1:0] NoticeLimitRst     = 8'd2;

  localparam logic [HoursW-1:0] MaxSuspendHours = 8'd24;
  localparam logic [16:0]       SecPerHour      = 17'd3600;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_CHECKIN = 2'd1,
    FUNC_RESET   = 2'd2,
    FUNC_SUSPEND = 2'd3
  } cew_func_e;

  typedef enum logic [1:0] {
    CFG_CHECKIN_INTERVAL = 2'd0,
    CFG_PANIC_DELAY      = 2'd1,
    CFG_NOTICE_DELAY     = 2'd2,
    CFG_NOTICE_LIMIT     = 2'd3
  } cew_cfg_idx_e;

  typedef struct packed {
    cew_func_e         func;
    logic [TimeW-1:0]  now_seconds;
    logic [HoursW-1:0] suspend_hours;
  } cew_req_t;

  typedef struct packed {
    logic checkin_missed;
    logic panic_fired;
    logic notice_fired;
    logic panic_mode;
  } cew_rsp_t;

  // Add two times, clamp at all ones instead of wrapping.
  function automatic logic [TimeW-1:0] cew_sat_add(input logic [TimeW-1:0] a,
                                                   input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

### design/checkin_escalation_watchdog.sv
// Top level of the check-in escalation watchdog: request and result registers plus state.
// The watchdog takes one request per clock cycle while req_stall_o is low and returns one
// result per request: a request is first held in an input register, then all
// three escalation stages (check-in, panic, notice) are evaluated combinationally
// against the stored deadlines and the result lands in an output register. Throughput is one
// request per cycle unless the consumer stalls the output; a new
// request is taken while a finished result still waits, and req_stall_o rises only when
// both registers are full and the consumer stalls. Each deadline sum saturates at all
// ones, so an armed stage is never disarmed by overflow. Configuration registers take
// effect on the next evaluated request and must be written only while the block is idle.
module checkin_escalation_watchdog (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_stall_o,
  input  cew_pkg::cew_req_t         req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_stall_i,
  output cew_pkg::cew_rsp_t         rsp_o,
  input  logic                      cfg_we_i,
  input  cew_pkg::cew_cfg_idx_e     cfg_idx_i,
  input  logic [cew_pkg::CfgW-1:0]  cfg_wdata_i
);
  import cew_pkg::*;

  // Configuration registers.
  logic [TimeW-1:0]  checkin_interval_q, panic_delay_q, notice_delay_q;
  logic [CountW-1:0] notice_limit_q;

  // Watchdog state; a zero deadline means the stage is unarmed.
  logic [TimeW-1:0]  checkin_dl_q, checkin_dl_d;
  logic [TimeW-1:0]  panic_dl_q, panic_dl_d;
  logic [TimeW-1:0]  notice_dl_q, notice_dl_d;
  logic [TimeW-1:0]  suspend_end_q, suspend_end_d;
  logic [CountW-1:0] notice_cnt_q, notice_cnt_d;

  // Input and result registers.
  logic     in_valid_q, out_valid_q;
  cew_req_t in_q;
  cew_rsp_t out_q, out_d;

  logic out_free, in_adv, in_take;

  // Drain the input register whenever the result register is empty or being taken.
  assign out_free    = !out_valid_q || !rsp_stall_i;
  assign in_adv      = in_valid_q && out_free;
  assign req_stall_o = in_valid_q && !out_free;
  assign in_take     = req_valid_i && !req_stall_o;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  // Shared sums against the current time.
  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  now_plus_ci, now_plus_pd, now_plus_nd, now_plus_susp;
  logic [4:0]        hours_eff;
  logic [16:0]       susp_secs;
  logic              suspended, c_fire, p_fire, n_fire;

  assign now         = in_q.now_seconds;
  assign now_plus_ci = cew_sat_add(now, checkin_interval_q);
  assign now_plus_pd = cew_sat_add(now, panic_delay_q);
  assign now_plus_nd = cew_sat_add(now, notice_delay_q);

  // Treat suspensions longer than a day as zero.
  assign hours_eff     = (in_q.suspend_hours > MaxSuspendHours) ? 5'd0
                                                                : in_q.suspend_hours[4:0];
  assign susp_secs     = 17'(hours_eff) * SecPerHour;
  assign now_plus_susp = cew_sat_add(now, 32'(susp_secs));

  // Stage firings. A stage that just armed its successor leaves that successor's
  // deadline at or after now, so the successor cannot fire in the same tick; only
  // the older deadlines need comparing.
  assign suspended = suspend_end_q > now;
  assign c_fire    = (checkin_dl_q != '0) && !suspended && (now > checkin_dl_q);
  assign p_fire    = !c_fire && (panic_dl_q != '0) && (now > panic_dl_q);
  assign n_fire    = !p_fire && (notice_dl_q != '0) && (now > notice_dl_q);

  always_comb begin
    checkin_dl_d  = checkin_dl_q;
    panic_dl_d    = panic_dl_q;
    notice_dl_d   = notice_dl_q;
    suspend_end_d = suspend_end_q;
    notice_cnt_d  = notice_cnt_q;
    out_d         = '0;

    unique case (in_q.func)
      FUNC_TICK: begin
        // Check-in stage: a running suspension pushes the deadline out.
        if (checkin_dl_q != '0) begin
          if (suspended) begin
            checkin_dl_d = suspend_end_q;
          end else begin
            suspend_end_d = '0;
          end
        end
        if (c_fire) begin
          checkin_dl_d = now_plus_ci;
          panic_dl_d   = now_plus_pd;
        end
        // Panic stage: re-arm itself and arm the notice stage.
        if (p_fire) begin
          panic_dl_d  = now_plus_ci;
          notice_dl_d = now_plus_nd;
        end
        // Notice stage: count, then start over from a fresh check-in window.
        if (n_fire) begin
          if (notice_cnt_q != {CountW{1'b1}}) begin
            notice_cnt_d = notice_cnt_q + 1'b1;
          end
          checkin_dl_d = now_plus_ci;
          panic_dl_d   = '0;
          notice_dl_d  = '0;
        end
        out_d.checkin_missed = c_fire;
        out_d.panic_fired    = p_fire;
        out_d.notice_fired   = n_fire;
      end
      FUNC_CHECKIN: begin
        checkin_dl_d = now_plus_ci;
        panic_dl_d   = '0;
        notice_dl_d  = '0;
      end
      FUNC_RESET: begin
        // Like a check-in, and also drop the notice history; keep the suspension.
        checkin_dl_d = now_plus_ci;
        panic_dl_d   = '0;
        notice_dl_d  = '0;
        notice_cnt_d = '0;
      end
      FUNC_SUSPEND: begin
        suspend_end_d = now_plus_susp;
      end
      default: begin
        checkin_dl_d = checkin_dl_q;
      end
    endcase

    out_d.panic_mode = notice_cnt_d > notice_limit_q;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      checkin_interval_q <= CheckinIntervalRst;
      panic_delay_q      <= PanicDelayRst;
      notice_delay_q     <= NoticeDelayRst;
      notice_limit_q     <= NoticeLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHECKIN_INTERVAL: checkin_interval_q <= cfg_wdata_i[TimeW-1:0];
        CFG_PANIC_DELAY:      panic_delay_q      <= cfg_wdata_i[TimeW-1:0];
        CFG_NOTICE_DELAY:     notice_delay_q     <= cfg_wdata_i[TimeW-1:0];
        CFG_NOTICE_LIMIT:     notice_limit_q     <= cfg_wdata_i[CountW-1:0];
        default:              notice_limit_q     <= notice_limit_q;
      endcase
    end
  end

  // Watchdog state: advance once per evaluated request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      checkin_dl_q  <= '0;
      panic_dl_q    <= '0;
      notice_dl_q   <= '0;
      suspend_end_q <= '0;
      notice_cnt_q  <= '0;
    end else if (in_adv) begin
      checkin_dl_q  <= checkin_dl_d;
      panic_dl_q    <= panic_dl_d;
      notice_dl_q   <= notice_dl_d;
      suspend_end_q <= suspend_end_d;
      notice_cnt_q  <= notice_cnt_d;
    end
  end

  // Handshake control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (in_adv) begin
        in_valid_q <= 1'b0;
      end
      if (in_adv) begin
        out_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= req_i;
    end
    if (in_adv) begin
      out_q <= out_d;
    end
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the check-in escalation watchdog.
`timescale 1ns / 100ps

module testbench;
  import cew_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned PrintCap   = 100;
  localparam logic [TimeW-1:0]  HourSeconds     = 32'd3600;
  localparam logic [HoursW-1:0] SuspendHoursMax = 8'd24;

  // Request streams: well-formed escalation chains, the same without the
  // counter-clearing reset operation, and unshaped noise.
  typedef enum {PAT_ESCALATE, PAT_SATURATE, PAT_NOISE} pattern_e;

  typedef struct {
    cew_func_e         func;
    logic [TimeW-1:0]  now;
    logic [HoursW-1:0] hours;
    bit                typed;
    cew_rsp_t          flags;
  } script_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              req_valid_i;
  logic              req_stall_o;
  cew_req_t          req_i;
  logic              rsp_valid_o;
  logic              rsp_stall_i;
  cew_rsp_t          rsp_o;
  logic              cfg_we_i;
  cew_cfg_idx_e      cfg_idx_i;
  logic [CfgW-1:0]   cfg_wdata_i;

  // Shadow copy of the configuration and the escalation state.
  logic [TimeW-1:0]  cfg_interval;
  logic [TimeW-1:0]  cfg_panic_delay;
  logic [TimeW-1:0]  cfg_notice_delay;
  logic [CountW-1:0] cfg_notice_limit;
  logic [TimeW-1:0]  dl_checkin;
  logic [TimeW-1:0]  dl_panic;
  logic [TimeW-1:0]  dl_notice;
  logic [TimeW-1:0]  pause_end;
  logic [CountW-1:0] notices_sent;

  cew_rsp_t          expected_flags[$];
  cew_rsp_t          oldest;
  logic [TimeW-1:0]  wall_time;
  int unsigned       burst_left;
  int unsigned       mismatches;
  int unsigned       results_seen;
  int unsigned       cycle_count;
  int unsigned       stall_style;
  int unsigned       stall_window;

  // Directed opening: reset state, saturation at both ends of time, one full
  // escalation chain up to panic mode, suspension holding the check-in
  // deadline, suspend hours above the cap, and the equal-time boundary.
  script_row_t script [26] = '{
    '{FUNC_TICK,    32'd0,          8'd0,   1'b1, 4'b0000}, // nothing armed
    '{FUNC_TICK,    32'hFFFF_FFFF,  8'd0,   1'b1, 4'b0000},
    '{FUNC_SUSPEND, 32'd1000,       8'd255, 1'b1, 4'b0000}, // hours over cap
    '{FUNC_CHECKIN, 32'd1000,       8'd0,   1'b1, 4'b0000},
    '{FUNC_TICK,    32'd2000,       8'd0,   1'b1, 4'b0000},
    '{FUNC_TICK,    32'd44201,      8'd0,   1'b1, 4'b1000}, // check-in missed
    '{FUNC_TICK,    32'd44502,      8'd0,   1'b1, 4'b0100}, // panic stage
    '{FUNC_TICK,    32'd44623,      8'd0,   1'b1, 4'b0010}, // first notice
    '{FUNC_TICK,    32'd87824,      8'd0,   1'b0, 4'b0000},
    '{FUNC_TICK,    32'd88125,      8'd0,   1'b0, 4'b0000},
    '{FUNC_TICK,    32'd88246,      8'd0,   1'b0, 4'b0000},
    '{FUNC_TICK,    32'd131447,     8'd0,   1'b0, 4'b0000},
    '{FUNC_TICK,    32'd131748,     8'd0,   1'b0, 4'b0000},
    '{FUNC_TICK,    32'd131869,     8'd0,   1'b1, 4'b0011}, // third notice
    '{FUNC_CHECKIN, 32'd200000,     8'd7,   1'b1, 4'b0001},
    '{FUNC_SUSPEND, 32'd200000,     8'd24,  1'b1, 4'b0001},
    '{FUNC_TICK,    32'd250000,     8'd0,   1'b1, 4'b0001}, // held by suspend
    '{FUNC_TICK,    32'd286400,     8'd0,   1'b1, 4'b0001}, // equal, no fire
    '{FUNC_TICK,    32'd286401,     8'd0,   1'b1, 4'b1001},
    '{FUNC_RESET,   32'd300000,     8'd255, 1'b1, 4'b0000},
    '{FUNC_SUSPEND, 32'hFFFF_F000,  8'd24,  1'b1, 4'b0000}, // clamps to max
    '{FUNC_TICK,    32'hFFFF_FFFE,  8'd0,   1'b1, 4'b0000},
    '{FUNC_TICK,    32'hFFFF_FFFF,  8'd0,   1'b1, 4'b0000}, // max never fires
    '{FUNC_SUSPEND, 32'd5,          8'd25,  1'b1, 4'b0000},
    '{FUNC_CHECKIN, 32'hFFFF_FFFF,  8'd0,   1'b1, 4'b0000},
    '{FUNC_TICK,    32'd0,          8'd255, 1'b1, 4'b0000}
  };

  checkin_escalation_watchdog u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp a time sum at all ones; a deadline must never wrap to unarmed.
  function automatic logic [TimeW-1:0] add_clamped(input logic [TimeW-1:0] a,
                                                   input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

  // Advance the shadow watchdog by one request and return its flags.
  function automatic cew_rsp_t evaluate_watchdog(input cew_req_t r);
    cew_rsp_t          flags;
    logic [HoursW-1:0] hrs;
    flags = '0;
    case (r.func)
      FUNC_TICK: begin
        // Stages run in order; a fired stage arms the one after it.
        if (dl_checkin != '0) begin
          if (pause_end > r.now_seconds) begin
            dl_checkin = pause_end;
          end else begin
            pause_end = '0;
            if (r.now_seconds > dl_checkin) begin
              dl_checkin = add_clamped(r.now_seconds, cfg_interval);
              dl_panic = add_clamped(r.now_seconds, cfg_panic_delay);
              flags.checkin_missed = 1'b1;
            end
          end
        end
        if (dl_panic != '0 && r.now_seconds > dl_panic) begin
          dl_panic = add_clamped(r.now_seconds, cfg_interval);
          dl_notice = add_clamped(r.now_seconds, cfg_notice_delay);
          flags.panic_fired = 1'b1;
        end
        if (dl_notice != '0 && r.now_seconds > dl_notice) begin
          if (notices_sent != '1) begin
            notices_sent++;
          end
          dl_checkin = add_clamped(r.now_seconds, cfg_interval);
          dl_panic = '0;
          dl_notice = '0;
          flags.notice_fired = 1'b1;
        end
      end
      FUNC_CHECKIN, FUNC_RESET: begin
        // Reset also clears the notice counter; the suspension survives.
        if (r.func == FUNC_RESET) begin
          notices_sent = '0;
        end
        dl_checkin = add_clamped(r.now_seconds, cfg_interval);
        dl_panic = '0;
        dl_notice = '0;
      end
      default: begin
        hrs = (r.suspend_hours > SuspendHoursMax) ? '0 : r.suspend_hours;
        pause_end = add_clamped(r.now_seconds, HourSeconds * hrs);
      end
    endcase
    flags.panic_mode = (notices_sent > cfg_notice_limit);
    return flags;
  endfunction

  // Build the next random request. Shaped streams mostly land just past the
  // nearest armed deadline so that every stage keeps firing.
  function automatic cew_req_t next_request(input pattern_e mode);
    cew_req_t         r;
    logic [TimeW-1:0] soonest;
    int unsigned      pick;
    int unsigned      tick_share;
    if (mode == PAT_NOISE) begin
      r.func = cew_func_e'($urandom_range(0, 3));
      r.now_seconds = $urandom();
      r.suspend_hours = 8'($urandom_range(0, 255));
      return r;
    end
    soonest = '1;
    if (dl_checkin != '0 && dl_checkin < soonest) soonest = dl_checkin;
    if (dl_panic != '0 && dl_panic < soonest) soonest = dl_panic;
    if (dl_notice != '0 && dl_notice < soonest) soonest = dl_notice;

    tick_share = (mode == PAT_SATURATE) ? 94 : 76;
    pick = $urandom_range(0, 99);
    if (pick < tick_share) begin
      r.func = FUNC_TICK;
    end else if (pick < tick_share + (100 - tick_share) / 2) begin
      r.func = FUNC_CHECKIN;
    end else if (mode == PAT_ESCALATE && pick < 96) begin
      r.func = FUNC_RESET;
    end else begin
      r.func = FUNC_SUSPEND;
    end

    pick = $urandom_range(0, 99);
    if (soonest != '1 && soonest >= wall_time && pick < 85) begin
      wall_time = add_clamped(soonest, $urandom_range(mode == PAT_SATURATE ? 1 : 0, 3));
    end else if (mode == PAT_ESCALATE && pick >= 94) begin
      wall_time = $urandom();
    end else begin
      wall_time = add_clamped(wall_time, $urandom_range(0, 40));
    end
    r.now_seconds = wall_time;
    r.suspend_hours = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 2));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    end
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    end
  endtask

  // Offer one request, hold it until accepted, then log its expected flags.
  // Bursts end with a random gap; some bursts run straight into the next.
  task automatic push_request(input cew_req_t r, input bit typed, input cew_rsp_t typed_flags);
    cew_rsp_t    predicted;
    int unsigned gap;
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    predicted = evaluate_watchdog(r);
    expected_flags.push_back(typed ? typed_flags : predicted);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Drop valid and wait until every outstanding request has its result.
  task automatic drain_results();
    req_valid_i <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write per clock; the caller drops the write enable.
  task automatic write_register(input cew_cfg_idx_e idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CHECKIN_INTERVAL: cfg_interval = data;
      CFG_PANIC_DELAY:      cfg_panic_delay = data;
      CFG_NOTICE_DELAY:     cfg_notice_delay = data;
      default:              cfg_notice_limit = data[CountW-1:0];
    endcase
  endtask

  // Reprogram all registers on an idle block, then run one stream of requests.
  task automatic run_phase(input logic [TimeW-1:0] interval, input logic [TimeW-1:0] panic,
                           input logic [TimeW-1:0] notice, input logic [CountW-1:0] limit,
                           input pattern_e mode, input int unsigned count);
    logic [CfgW-1:0] limit_word;
    drain_results();
    limit_word = $urandom();
    limit_word[CountW-1:0] = limit;
    write_register(CFG_CHECKIN_INTERVAL, interval);
    write_register(CFG_PANIC_DELAY, panic);
    write_register(CFG_NOTICE_DELAY, notice);
    write_register(CFG_NOTICE_LIMIT, limit_word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    repeat (count) push_request(next_request(mode), 1'b0, '0);
  endtask

  // Receiver: switch between no stall, scattered stalls and long stall runs.
  always @(posedge clk_i) begin
    if (stall_window == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_window = $urandom_range(20, 200);
    end else begin
      stall_window--;
    end
    case (stall_style)
      0:       rsp_stall_i <= 1'b0;
      1:       rsp_stall_i <= ($urandom_range(0, 2) == 0);
      default: rsp_stall_i <= ($urandom_range(0, 9) == 0) ? ~rsp_stall_i : rsp_stall_i;
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (expected_flags.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        oldest = expected_flags.pop_front();
        check_flag("checkin_missed", rsp_o.checkin_missed, oldest.checkin_missed);
        check_flag("panic_fired", rsp_o.panic_fired, oldest.panic_fired);
        check_flag("notice_fired", rsp_o.notice_fired, oldest.notice_fired);
        check_flag("panic_mode", rsp_o.panic_mode, oldest.panic_mode);
      end
      results_seen++;
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cew_req_t r;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    rsp_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CHECKIN_INTERVAL;
    cfg_wdata_i = '0;
    cfg_interval = CheckinIntervalRst;
    cfg_panic_delay = PanicDelayRst;
    cfg_notice_delay = NoticeDelayRst;
    cfg_notice_limit = NoticeLimitRst;
    dl_checkin = '0;
    dl_panic = '0;
    dl_notice = '0;
    pause_end = '0;
    notices_sent = '0;
    wall_time = '0;
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    stall_style = 0;
    stall_window = 0;
    burst_left = $urandom_range(1, 24);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part runs on the reset configuration.
    foreach (script[i]) begin
      r.func = script[i].func;
      r.now_seconds = script[i].now;
      r.suspend_hours = script[i].hours;
      push_request(r, script[i].typed, script[i].flags);
    end

    // Short delays keep every stage busy.
    run_phase($urandom_range(20, 200), $urandom_range(1, 19), $urandom_range(1, 19),
              8'($urandom_range(0, 4)), PAT_ESCALATE, 200);
    // No reset operation: drive the notice counter into saturation.
    run_phase(32'd100, 32'd3, 32'd2, 8'd254, PAT_SATURATE, 1050);
    // Upper extremes: every sum clamps.
    run_phase('1, '1, '1, 8'd255, PAT_ESCALATE, 100);
    // Lower extremes, including a zero delay.
    run_phase(32'd1, 32'd0, 32'd1, 8'd0, PAT_ESCALATE, 100);
    // Unshaped requests on a random setting with a zero interval.
    run_phase(32'd0, $urandom(), $urandom(), 8'($urandom_range(0, 255)), PAT_NOISE, 80);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/cew_pkg.sv
design/checkin_escalation_watchdog.sv
dv/testbench.sv
